FILE: hw/rtl/rsas_pkg.sv
// Package for the rotated sorted array search block.
// Holds the operation codes, the sequencer state type and parameter defaults.
// No dependencies.
`default_nettype none

package rsas_pkg;

  localparam int MAX_ELEMENTS_DEF = 4096;
  localparam int DATA_BITS_DEF    = 32;
  localparam int VALUE_W          = 32;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } rsas_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rotated_sorted_array_search.sv
// Top level of the rotated sorted array search block.
// Depends on rsas_pkg and rsas_store.
//
// Usage: every input transaction is either a load (op = load) that appends
// value to the current array, or a search (op = search) that returns one
// output transaction whose found bit tells whether value is in the array.
// A load with last set closes the array; the next load starts a new one.
// A load produces no output transaction.
// A search runs a setup step, one binary search step per cycle over the
// element memory (at most ceil(log2(MAX_ELEMENTS + 1)) steps, 13 at the
// default depth), and a final step that places the result in the output
// register. The step rate is set by the single read port of the element
// memory, whose registered data feeds the compare and the next address in
// the same cycle.
// The first element and, for a rotated array, the smallest and largest
// element are kept in registers, so the search setup needs no memory reads.
// Reset clears the element count, pivot and closed flag; memory contents
// are not cleared. When the receiver stalls, a finished result waits in the
// output register; loads are still taken, and the next search waits for the
// output register to drain before it finishes.
`default_nettype none

module rotated_sorted_array_search #(
  parameter int MAX_ELEMENTS = rsas_pkg::MAX_ELEMENTS_DEF,
  parameter int DATA_BITS    = rsas_pkg::DATA_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_op,
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] in_value,
  input  wire logic                               in_last,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_found
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int EXT_W = (DATA_BITS > rsas_pkg::VALUE_W) ? DATA_BITS : rsas_pkg::VALUE_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
  localparam logic [DATA_BITS-1:0] SIGN_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

  rsas_pkg::rsas_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     pivot_r, pivot_nxt;
  logic                 closed_r, closed_nxt;
  logic [DATA_BITS-1:0] first_key_r, first_key_nxt;
  logic [DATA_BITS-1:0] last_key_r, last_key_nxt;
  logic [DATA_BITS-1:0] min_key_r, min_key_nxt;
  logic [DATA_BITS-1:0] max_key_r, max_key_nxt;
  logic [DATA_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]     mid_r, mid_nxt;
  logic                 hit_r, hit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;

  logic [EXT_W-1:0]     value_ext;
  logic [DATA_BITS-1:0] in_key;
  logic                 in_fire;
  logic [CNT_W-1:0]     eff_count;
  logic [CNT_W-1:0]     eff_pivot;

  logic [CNT_W-1:0]     setup_lo, setup_hi, setup_mid;
  logic                 setup_reject;
  logic                 setup_go;

  logic [DATA_BITS-1:0] rd_data;
  logic                 run_eq, run_gt;
  logic [CNT_W-1:0]     run_lo, run_hi, run_mid;
  logic                 run_go;

  logic                 wr_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 out_slot_free;

  assign value_ext = EXT_W'(unsigned'(in_value));
  assign in_key    = value_ext[DATA_BITS-1:0] ^ SIGN_BIT;
  assign in_ready  = (state_r == rsas_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign eff_count = closed_r ? '0 : count_r;
  assign eff_pivot = closed_r ? '0 : pivot_r;
  assign wr_en     = in_fire && (in_op == rsas_pkg::OP_LOAD) && (eff_count < MAX_CNT);
  assign out_slot_free = !out_valid_r || out_ready;

  always_comb begin
    setup_lo     = '0;
    setup_hi     = count_r;
    setup_reject = 1'b0;
    if (count_r == '0) begin
      setup_reject = 1'b1;
    end else if (pivot_r != '0) begin
      if ((in_key < min_key_r) || (in_key > max_key_r)) begin
        setup_reject = 1'b1;
      end else if (first_key_r <= in_key) begin
        setup_hi = pivot_r;
      end else begin
        setup_lo = pivot_r;
      end
    end
    setup_go  = !setup_reject && (setup_lo < setup_hi);
    setup_mid = setup_lo + ((setup_hi - setup_lo) >> 1);
  end

  always_comb begin
    run_eq = (key_r == rd_data);
    run_gt = (key_r > rd_data);
    run_lo = run_gt ? (mid_r + CNT_W'(1)) : lo_r;
    run_hi = run_gt ? hi_r : mid_r;
    run_go = (run_lo < run_hi);
    run_mid = run_lo + ((run_hi - run_lo) >> 1);
  end

  assign rd_addr = (state_r == rsas_pkg::ST_IDLE) ? setup_mid[IDX_W-1:0] : run_mid[IDX_W-1:0];

  rsas_store #(
    .DEPTH  (MAX_ELEMENTS),
    .WIDTH  (DATA_BITS),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (eff_count[IDX_W-1:0]),
    .wr_data (in_key),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pivot_nxt     = pivot_r;
    closed_nxt    = closed_r;
    first_key_nxt = first_key_r;
    last_key_nxt  = last_key_r;
    min_key_nxt   = min_key_r;
    max_key_nxt   = max_key_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;

    unique case (state_r)
      rsas_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_op == rsas_pkg::OP_LOAD) begin
            count_nxt  = eff_count;
            pivot_nxt  = eff_pivot;
            closed_nxt = in_last;
            if (eff_count < MAX_CNT) begin
              if ((eff_count != '0) && (eff_pivot == '0) && (last_key_r > in_key)) begin
                pivot_nxt   = eff_count;
                min_key_nxt = in_key;
                max_key_nxt = last_key_r;
              end
              if (eff_count == '0) begin
                first_key_nxt = in_key;
              end
              last_key_nxt = in_key;
              count_nxt    = eff_count + CNT_W'(1);
            end
          end else begin
            key_nxt = in_key;
            lo_nxt  = setup_lo;
            hi_nxt  = setup_hi;
            mid_nxt = setup_mid;
            hit_nxt = 1'b0;
            if (setup_go) begin
              state_nxt = rsas_pkg::ST_RUN;
            end else begin
              state_nxt = rsas_pkg::ST_DONE;
            end
          end
        end
      end
      rsas_pkg::ST_RUN: begin
        if (run_eq) begin
          hit_nxt   = 1'b1;
          state_nxt = rsas_pkg::ST_DONE;
        end else if (run_go) begin
          lo_nxt  = run_lo;
          hi_nxt  = run_hi;
          mid_nxt = run_mid;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = rsas_pkg::ST_DONE;
        end
      end
      rsas_pkg::ST_DONE: begin
        if (out_slot_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          state_nxt     = rsas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rsas_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsas_pkg::ST_IDLE;
      count_r     <= '0;
      pivot_r     <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pivot_r     <= pivot_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_key_r <= first_key_nxt;
    last_key_r  <= last_key_nxt;
    min_key_r   <= min_key_nxt;
    max_key_r   <= max_key_nxt;
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    hit_r       <= hit_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rsas_store.sv
// Element store of the rotated sorted array search block.
// One write port and one read port with registered read data.
// No dependencies.
`default_nettype none

module rsas_store #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
